// File: rtl/core/ppclsu_pkg.sv
package ppclsu_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_AW   = 5;
  localparam int DATA_W   = 32;

  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD     = 2'd0;
  localparam op_t OP_STORE    = 2'd1;
  localparam op_t OP_LOAD_IMM = 2'd2;
  localparam op_t OP_NOP      = 2'd3;

  typedef logic [1:0] acc_size_t;
  localparam acc_size_t SZ_BYTE = 2'd0;
  localparam acc_size_t SZ_HALF = 2'd1;
  localparam acc_size_t SZ_WORD = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RESULT
  } lsu_state_t;

  // Size code three behaves as a word access.
  function automatic logic [2:0] size_bytes(acc_size_t sz);
    logic [2:0] n;
    case (sz)
      SZ_BYTE: n = 3'd1;
      SZ_HALF: n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/ppc_load_store_unit.sv
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+--------------------------
// input     | in_operation .. in_immediate                     | taken when start & !busy
// result    | out_status, out_effective_address, out_data_value| out_valid, one cycle
//
// Each word passes a register file read at the accepting edge, then
// address add with byte memory read, then result and write-back; busy is high
// in the address and result steps, so the next word is taken at the earliest in the cycle after.
// After reset a clearing pass zeroes the byte memory, one row of four bytes
// per cycle, with busy high throughout.
// The result is shown for exactly one cycle; the receiver cannot stall.
module ppc_load_store_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ppclsu_pkg::op_t               in_operation,
  input  ppclsu_pkg::acc_size_t         in_access_size,
  input  logic                          in_sign_extend,
  input  logic                          in_update_base,
  input  logic                          in_indexed,
  input  ppclsu_pkg::reg_idx_t          in_data_reg,
  input  ppclsu_pkg::reg_idx_t          in_base_reg,
  input  ppclsu_pkg::reg_idx_t          in_index_reg,
  input  logic signed [15:0]            in_displacement,
  input  logic signed [31:0]            in_immediate,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [31:0]                   out_effective_address,
  output logic [31:0]                   out_data_value
);
  import ppclsu_pkg::*;

  localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int ROW_W      = $clog2(BANK_DEPTH);

  lsu_state_t state_r, state_nxt;
  logic [ROW_W-1:0] clr_row_r;
  logic             accept;

  // latched instruction word
  op_t       op_r;
  acc_size_t sz_r;
  logic      sext_r, upd_r, idx_r;
  reg_idx_t  rd_r, ra_r;
  logic [15:0] disp_r;
  word_t     imm_r;

  // register file
  word_t     gpr_mem [NUM_REGS];
  logic [NUM_REGS-1:0] gpr_vld_r;
  word_t     gpr_a_q, gpr_b_q;
  logic      gpr_a_vld_q, gpr_b_vld_q;
  reg_idx_t  gpr_raddr_a;
  logic      gpr_we;
  reg_idx_t  gpr_waddr;
  word_t     gpr_wdata;
  word_t     gpr_a, gpr_b;

  // address stage
  word_t     base, offset, ea;
  logic [2:0] nbytes;
  logic      oob, mem_op;
  word_t     ea_r;
  logic      oob_r;

  // byte memory, four byte lanes
  logic [ROW_W-1:0] bank_row [4];
  logic [ROW_W-1:0] row_r [4];
  logic             bank_we [4];
  logic [ROW_W-1:0] bank_wrow [4];
  logic [7:0]       bank_wdata [4];
  logic [7:0]       bank_q [4];

  // result stage
  word_t     st_val, st_word, ld_val;
  logic [7:0] st_byte [4];
  logic [7:0] ld_byte [4];
  logic      clearing;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state_r == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_row_r <= clr_row_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_row_r == ROW_W'(BANK_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      sz_r   <= in_access_size;
      sext_r <= in_sign_extend;
      upd_r  <= in_update_base;
      idx_r  <= in_indexed;
      rd_r   <= in_data_reg;
      ra_r   <= in_base_reg;
      disp_r <= in_displacement;
      imm_r  <= in_immediate;
    end
  end

  // Port A reads the base at accept, then the data register for stores.
  assign gpr_raddr_a = (state_r == ST_ADDR) ? rd_r : in_base_reg;

  always_ff @(posedge clk) begin
    if (gpr_we) gpr_mem[gpr_waddr] <= gpr_wdata;
    gpr_a_q     <= gpr_mem[gpr_raddr_a];
    gpr_b_q     <= gpr_mem[in_index_reg];
    gpr_a_vld_q <= gpr_vld_r[gpr_raddr_a];
    gpr_b_vld_q <= gpr_vld_r[in_index_reg];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_vld_r <= '0;
    end else if (gpr_we) begin
      gpr_vld_r[gpr_waddr] <= 1'b1;
    end
  end

  assign gpr_a = gpr_a_vld_q ? gpr_a_q : '0;
  assign gpr_b = gpr_b_vld_q ? gpr_b_q : '0;

  always_comb begin
    base   = (ra_r == '0 && !upd_r) ? '0 : gpr_a;
    offset = idx_r ? gpr_b : {{16{disp_r[15]}}, disp_r};
    ea     = base + offset;
    nbytes = size_bytes(sz_r);
    oob    = ({1'b0, ea} + 33'(nbytes)) > 33'(MEM_BYTES);
    mem_op = (op_r == OP_LOAD) || (op_r == OP_STORE);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      ea_r  <= ea;
      oob_r <= oob;
      for (int b = 0; b < 4; b++) row_r[b] <= bank_row[b];
    end
  end

  // store data: truncate, then left-align so byte 0 goes to the lowest address
  always_comb begin
    st_val  = gpr_a;
    st_word = gpr_a;
    case (sz_r)
      SZ_BYTE: begin
        st_val  = {24'd0, gpr_a[7:0]};
        st_word = {gpr_a[7:0], 24'd0};
      end
      SZ_HALF: begin
        st_val  = {16'd0, gpr_a[15:0]};
        st_word = {gpr_a[15:0], 16'd0};
      end
      default: begin
        st_val  = gpr_a;
        st_word = gpr_a;
      end
    endcase
    st_byte[0] = st_word[31:24];
    st_byte[1] = st_word[23:16];
    st_byte[2] = st_word[15:8];
    st_byte[3] = st_word[7:0];
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];
    word_t      row_addr;
    logic [1:0] lane;

    // lowest address at or above ea that falls in this lane
    assign row_addr    = ea + 32'(3 - b);
    assign bank_row[b] = row_addr[ROW_W+1:2];
    assign lane        = 2'(b) - ea_r[1:0];

    always_comb begin
      bank_we[b]    = 1'b0;
      bank_wrow[b]  = row_r[b];
      bank_wdata[b] = st_byte[lane];
      if (clearing) begin
        bank_we[b]    = 1'b1;
        bank_wrow[b]  = clr_row_r;
        bank_wdata[b] = '0;
      end else if (state_r == ST_RESULT && op_r == OP_STORE && !oob_r &&
                   {1'b0, lane} < nbytes) begin
        bank_we[b] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (bank_we[b]) mem[bank_wrow[b]] <= bank_wdata[b];
      bank_q[b] <= mem[bank_row[b]];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) ld_byte[i] = bank_q[2'(ea_r[1:0] + 2'(i))];
    case (sz_r)
      SZ_BYTE: ld_val = {{24{sext_r & ld_byte[0][7]}}, ld_byte[0]};
      SZ_HALF: ld_val = {{16{sext_r & ld_byte[0][7]}}, ld_byte[0], ld_byte[1]};
      default: ld_val = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};
    endcase
  end

  // Base update goes out in the address cycle; a load into the same register
  // is dropped so the update wins.
  always_comb begin
    gpr_we    = 1'b0;
    gpr_waddr = rd_r;
    gpr_wdata = ld_val;
    case (state_r)
      ST_ADDR: begin
        if (mem_op && upd_r && !oob) begin
          gpr_we    = 1'b1;
          gpr_waddr = ra_r;
          gpr_wdata = ea;
        end
      end
      ST_RESULT: begin
        if (op_r == OP_LOAD_IMM) begin
          gpr_we    = 1'b1;
          gpr_wdata = imm_r;
        end else if (op_r == OP_LOAD && !oob_r && !(upd_r && rd_r == ra_r)) begin
          gpr_we = 1'b1;
        end
      end
      default: gpr_we = 1'b0;
    endcase
  end

  always_comb begin
    out_valid             = (state_r == ST_RESULT);
    out_status            = 1'b0;
    out_effective_address = '0;
    out_data_value        = '0;
    case (op_r)
      OP_LOAD: begin
        out_status            = oob_r;
        out_effective_address = ea_r;
        out_data_value        = oob_r ? '0 : ld_val;
      end
      OP_STORE: begin
        out_status            = oob_r;
        out_effective_address = ea_r;
        out_data_value        = oob_r ? '0 : st_val;
      end
      OP_LOAD_IMM: out_data_value = imm_r;
      default:     out_data_value = '0;
    endcase
  end

endmodule
